### hdl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types, codes and byte classes of the reindent stream
// Payload structs, output phase codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam logic [3:0] MAX_NEST    = 4'd15;
  localparam int         SP_W        = 6;     // holds MAX_NEST * 4 spaces

  // input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // output phases, also the controller state codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_NL   = 3'd1;
  localparam logic [2:0] PH_SP   = 3'd2;
  localparam logic [2:0] PH_C1   = 3'd3;
  localparam logic [2:0] PH_C2   = 3'd4;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       sp_dec;
    logic [2:0] phase;
  } crs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_any;   // plan of the held byte has output
    logic new_nl;    // plan starts with a line break
    logic new_sp;    // plan has spaces
    logic sp_nz;     // stored plan has spaces left
    logic sp_one;    // one space left
    logic c2;        // stored plan has a second byte
  } crs_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ",") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "%") || (c == "=") || (c == "?") || (c == ":") || (c == "&") ||
           (c == "|") || (c == "<") || (c == ">") || (c == "!");
  endfunction

endpackage

### hdl/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl: output sequencer
// Walks the phases line break, spaces, first byte, second byte of one item.
// ----------------------------------------------------------------------------
module crs_ctrl import crs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  crs_sts_t sts,
  output crs_cmd_t cmd
);

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign take      = (state_r != PH_IDLE) && !out_stall;
  assign out_valid = (state_r != PH_IDLE);
  assign in_stall  = (state_r != PH_IDLE);

  // next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE: begin
        if (in_valid && sts.new_any) begin
          if (sts.new_nl) state_nxt = PH_NL;
          else if (sts.new_sp) state_nxt = PH_SP;
          else state_nxt = PH_C1;
        end
      end
      PH_NL: if (take) state_nxt = sts.sp_nz ? PH_SP : PH_C1;
      PH_SP: if (take && sts.sp_one) state_nxt = PH_C1;
      PH_C1: if (take) state_nxt = sts.c2 ? PH_C2 : PH_IDLE;
      PH_C2: if (take) state_nxt = PH_IDLE;
      default: state_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= PH_IDLE;
    else        state_r <= state_nxt;
  end

  // commands
  assign cmd.load   = in_valid && (state_r == PH_IDLE);
  assign cmd.sp_dec = take && (state_r == PH_SP);
  assign cmd.phase  = state_r;

endmodule

### hdl/crs_datapath.sv
// ----------------------------------------------------------------------------
// crs_datapath: lookahead state, byte classing and output plan
// Decides what the held byte emits and keeps the plan while it is sent.
// ----------------------------------------------------------------------------
module crs_datapath import crs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  crs_cmd_t  cmd,
  output crs_sts_t  sts,
  output out_item_t out_data
);

  // stream state
  logic [7:0] held_char_r, before_char_r;
  logic       held_valid_r, before_valid_r, skip_held_r;
  logic [3:0] nest_r;
  logic       line_start_r, space_pend_r;

  // stored plan
  logic            nl_r, c2v_r;
  logic [SP_W-1:0] sp_cnt_r;
  logic [7:0]      c1_r, c2_r;

  // handler results
  logic [7:0]      c, nxt;
  logic            nv, do_h;
  logic [SP_W-1:0] lead_cnt;
  logic            p_nl, p_c1v, p_c2v, p_skip;
  logic [SP_W-1:0] p_sp;
  logic [7:0]      p_c2;
  logic [3:0]      h_nest;
  logic            h_ls, h_sp;

  assign c    = held_char_r;
  assign nv   = (in_data.op == OP_CHAR);
  assign nxt  = nv ? in_data.char_in : 8'd0;
  assign do_h = held_valid_r && !skip_held_r;

  // indentation or owed space ahead of a plain byte, a doubled operator or an opening bracket
  always_comb begin
    if (line_start_r)      lead_cnt = {nest_r, 2'b00};
    else if (space_pend_r) lead_cnt = SP_W'(1);
    else                   lead_cnt = '0;
  end

  // handle the held byte
  always_comb begin
    p_nl   = 1'b0;
    p_sp   = '0;
    p_c1v  = 1'b0;
    p_c2v  = 1'b0;
    p_c2   = 8'd0;
    p_skip = 1'b0;
    h_nest = nest_r;
    h_ls   = line_start_r;
    h_sp   = 1'b0;
    if (is_ws(c)) begin
      h_sp = space_pend_r || (!line_start_r && before_valid_r && nv &&
                              is_alnum(before_char_r) && is_alnum(nxt));
    end else if (((c == ":") || (c == "+") || (c == "<")) && nv && (nxt == c)) begin
      p_sp   = lead_cnt;
      p_c1v  = 1'b1;
      p_c2v  = 1'b1;
      p_c2   = c;
      p_skip = 1'b1;
      h_ls   = 1'b0;
    end else if ((c == "{") || (c == "(") || (c == "[")) begin
      p_sp   = lead_cnt;
      p_c1v  = 1'b1;
      p_c2v  = 1'b1;
      p_c2   = CH_NL;
      if (nest_r < MAX_NEST) h_nest = nest_r + 4'd1;
      h_ls   = 1'b1;
    end else if ((c == "}") || (c == ")") || (c == "]")) begin
      if (nest_r != 4'd0) h_nest = nest_r - 4'd1;
      p_sp   = {h_nest, 2'b00};
      p_c1v  = 1'b1;
      h_ls   = 1'b0;
    end else if (c == ";") begin
      p_c1v  = 1'b1;
      p_c2v  = 1'b1;
      p_c2   = CH_NL;
      h_ls   = 1'b1;
    end else if (is_sep(c)) begin
      p_nl   = 1'b1;
      p_sp   = {nest_r, 2'b00};
      p_c1v  = 1'b1;
      p_c2v  = 1'b1;
      p_c2   = CH_SPACE;
      h_ls   = 1'b0;
    end else begin
      p_sp   = lead_cnt;
      p_c1v  = 1'b1;
      h_ls   = 1'b0;
    end
  end

  // stream state update on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r    <= 8'd0;
      held_valid_r   <= 1'b0;
      before_char_r  <= 8'd0;
      before_valid_r <= 1'b0;
      skip_held_r    <= 1'b0;
      nest_r         <= 4'd0;
      line_start_r   <= 1'b1;
      space_pend_r   <= 1'b0;
    end else if (cmd.load) begin
      if (in_data.op == OP_CHAR) begin
        if (held_valid_r) begin
          before_char_r  <= held_char_r;
          before_valid_r <= 1'b1;
        end
        if (do_h) begin
          nest_r       <= h_nest;
          line_start_r <= h_ls;
          space_pend_r <= h_sp;
        end
        held_char_r  <= in_data.char_in;
        held_valid_r <= 1'b1;
        skip_held_r  <= do_h && p_skip;
      end else begin
        held_char_r    <= 8'd0;
        held_valid_r   <= 1'b0;
        before_char_r  <= 8'd0;
        before_valid_r <= 1'b0;
        skip_held_r    <= 1'b0;
        nest_r         <= 4'd0;
        line_start_r   <= 1'b1;
        space_pend_r   <= 1'b0;
      end
    end
  end

  // plan registers and space counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nl_r     <= p_nl;
      sp_cnt_r <= p_sp;
      c1_r     <= c;
      c2_r     <= p_c2;
      c2v_r    <= p_c2v;
    end else if (cmd.sp_dec) begin
      sp_cnt_r <= sp_cnt_r - SP_W'(1);
    end
  end

  assign sts.new_any = do_h && p_c1v;
  assign sts.new_nl  = p_nl;
  assign sts.new_sp  = (p_sp != '0);
  assign sts.sp_nz   = (sp_cnt_r != '0);
  assign sts.sp_one  = (sp_cnt_r == SP_W'(1));
  assign sts.c2      = c2v_r;

  // output byte of the current phase
  always_comb begin
    case (cmd.phase)
      PH_NL:   out_data.char_out = CH_NL;
      PH_SP:   out_data.char_out = CH_SPACE;
      PH_C1:   out_data.char_out = c1_r;
      PH_C2:   out_data.char_out = c2_r;
      default: out_data.char_out = 8'd0;
    endcase
  end
  assign out_data.run_last = ((cmd.phase == PH_C1) && !c2v_r) || (cmd.phase == PH_C2);

endmodule

### hdl/code_reindent_stream.sv
// ----------------------------------------------------------------------------
// code_reindent_stream: streaming source reindenter
// Takes one source byte per item and emits the formatted text byte by byte.
// ----------------------------------------------------------------------------
// the first result byte of an item with output is valid in the cycle after the item is accepted
// each item gives N result bytes (N from 0 to 63), sent by the output sequencer
//   one byte per cycle while out_stall is low
// a new item is taken only once every byte of the previous one is taken
// reset: synchronous active-low rst_n clears the stream state, no lookahead held
module code_reindent_stream import crs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  crs_cmd_t cmd;
  crs_sts_t sts;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  crs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### hdl/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker: port-level checks of the reindent stream
// Output holds under stall, one item in flight, run ends cleanly.
// ----------------------------------------------------------------------------
module crs_checker import crs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // no new item while bytes of the current one are pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during output run");

  // last byte taken ends the run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.run_last |=> !out_valid)
    else $error("output continued after last byte");

  // a byte that is not last is followed by another
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=> out_valid)
    else $error("output run ended without last marker");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind code_reindent_stream crs_checker u_crs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
